// ===== sv/assert_macros.svh =====
// Assertion macros used by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while reset is low.
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("console assertion failed");
// Checked on every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("console assertion failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/tcw_pkg.sv =====
// Types and constants for the text console writer.
package tcw_pkg;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int POS_W = 13;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [15:0] BLANK_CELL = 16'h0F00;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic             print;
    logic             scroll;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cur_upd_t;

endpackage

// ===== sv/tcw_cursor.sv =====
// Cursor update for one character byte: control codes, wrap and scroll.
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [7:0]       char_code,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  output cur_upd_t         upd
);

  logic [COL_W:0] col_w;
  logic [ROW_W:0] row_w;
  logic           print;

  always_comb begin
    col_w = {1'b0, col};
    row_w = {1'b0, row};
    print = 1'b0;
    unique case (char_code)
      CH_LF: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      CH_TAB: col_w = col_w + (COL_W+1)'(4);
      CH_VT, CH_FF: row_w = row_w + 1'b1;
      CH_CR: col_w = '0;
      default: begin
        print = 1'b1;
        col_w = col_w + 1'b1;
      end
    endcase
    // tab overshoot is dropped, not carried into the next row
    if (col_w >= (COL_W+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    upd.print  = print;
    upd.scroll = 1'b0;
    upd.col    = col_w[COL_W-1:0];
    upd.row    = row_w[ROW_W-1:0];
    if (row_w >= (ROW_W+1)'(ROWS)) begin
      upd.scroll = 1'b1;
      upd.row    = ROW_W'(ROWS - 1);
    end
  end

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer: screen memory, cursor and the sweep sequencer.
// An accepted item passes through S_EXEC, then S_RDWAIT for an in-range cell
// read, S_SCROLL then S_CLEAR for a scroll, S_CLEAR for a clear, and S_DONE; one item at a time.
// A scroll walks the screen memory one cell a cycle, moving each row up one and
// then blanking the last row; a clear blanks every cell.
// After rst a clearing pass blanks the screen first.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // mode[1:0], char_code[9:2], cell_index[20:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cursor_pos[10:0], cell_value[26:11]
);

  `include "assert_macros.svh"

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  logic [ADDR_W-1:0] ptr;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_addr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [3:0]        fg_color;
  logic [3:0]        bg_color;
  logic [1:0]        mode;
  logic [7:0]        char_code;
  logic [10:0]       cell_index;
  logic [15:0]       res_cell;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  cur_upd_t          upd;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  idx_wide;
  logic              idx_ok;
  logic              last_src;
  logic              out_free;

  tcw_cursor #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cursor (
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .upd       (upd)
  );

  assign pos      = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
  assign idx_wide = POS_W'(cell_index);
  assign idx_ok   = idx_wide < POS_W'(CELLS);
  assign last_src = (ptr == ADDR_W'(CELLS - COLUMNS));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = ptr + ADDR_W'(COLUMNS);
    unique case (state)
      S_INIT, S_CLEAR: mem_we = 1'b1;
      S_EXEC: begin
        if (mode == MODE_PUT && upd.print) begin
          mem_we    = 1'b1;
          mem_waddr = pos[ADDR_W-1:0];
          mem_wdata = {bg_color, fg_color, char_code};
        end
        if (mode == MODE_READ && idx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = idx_wide[ADDR_W-1:0];
        end
      end
      S_SCROLL: begin
        mem_we    = copy_pend;
        mem_waddr = copy_addr;
        mem_wdata = rd_data;
        mem_re    = !last_src;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 4'd15;
      bg_color <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG: fg_color <= cfg_data;
        REG_BG: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode       <= s_tdata[1:0];
      char_code  <= s_tdata[9:2];
      cell_index <= s_tdata[20:10];
      res_cell   <= '0;
    end
    if (state == S_RDWAIT) begin
      res_cell <= rd_data;
    end
    if (state == S_SCROLL) begin
      copy_addr <= ptr;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {5'd0, res_cell, pos[10:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      copy_pend <= 1'b0;
      col       <= '0;
      row       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          ptr       <= '0;
          copy_pend <= 1'b0;
          unique case (mode)
            MODE_PUT: begin
              col   <= upd.col;
              row   <= upd.row;
              state <= upd.scroll ? S_SCROLL : S_DONE;
            end
            MODE_READ: state <= idx_ok ? S_RDWAIT : S_DONE;
            MODE_CLEAR: state <= S_CLEAR;
            default: state <= S_DONE;
          endcase
        end
        S_RDWAIT: state <= S_DONE;
        S_SCROLL: begin
          // read a row below, write the previous read one cell back
          copy_pend <= !last_src;
          if (last_src) begin
            state <= S_CLEAR;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_CLEAR: begin
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_DONE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  `TCW_ASSERT(a_accept_exec, (s_tvalid && s_tready) |=> (state == S_EXEC))
  `TCW_ASSERT(a_cursor_range, (32'(col) < COLUMNS) && (32'(row) < ROWS))
  `TCW_ASSERT(a_done_out, (state == S_DONE && out_free) |=> m_tvalid)
  `TCW_ASSERT_ALWAYS(a_reset_init, rst |=> (state == S_INIT && !m_tvalid))

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the text console writer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [10:0] pos;
    logic [15:0] cell_val;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_FG;
  logic [3:0]  cfg_data = 4'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;   // mode[1:0], char_code[9:2], cell_index[20:10]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // cursor_pos[10:0], cell_value[26:11]

  // Shadow copy of the console
  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [3:0]  fg_colour;
  logic [3:0]  bg_colour;

  console_result_t expected_results[$];
  bit failed = 0;
  bit src_idling = 1;
  bit sink_idling = 1;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
  endfunction

  // Applies one item to the shadow console and returns the result it gives
  function automatic console_result_t console_apply(logic [1:0] mode, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_result_t res;
    res.cell_val = 16'h0000;
    case (mode)
      MODE_PUT: begin
        case (ch)
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          CH_TAB: cur_col += 4;
          CH_VT, CH_FF: cur_row++;
          CH_CR: cur_col = 0;
          default: begin
            screen[cur_row * COLUMNS + cur_col] = {bg_colour, fg_colour, ch};
            cur_col++;
          end
        endcase
        // tab overshoot is dropped, not carried into the next row
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          scroll_screen();
          cur_row = ROWS - 1;
        end
      end
      MODE_READ: if (int'(idx) < CELLS) res.cell_val = screen[idx];
      MODE_CLEAR: blank_screen();
      default: ;
    endcase
    res.pos = 11'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Result checker
  always @(posedge clk) begin
    console_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual pos %0d cell %h",
                 $time, m_tdata[10:0], m_tdata[26:11]);
        failed = 1;
      end else begin
        e = expected_results.pop_front();
        if (m_tdata[10:0] !== e.pos) begin
          $display("%0t: cursor_pos mismatch, expected %0d actual %0d",
                   $time, e.pos, m_tdata[10:0]);
          failed = 1;
        end
        if (m_tdata[26:11] !== e.cell_val) begin
          $display("%0t: cell_value mismatch, expected %h actual %h",
                   $time, e.cell_val, m_tdata[26:11]);
          failed = 1;
        end
      end
    end
  end

  // Result sink with random back-pressure
  initial begin : sink
    int gap;
    @(negedge clk iff !rst);
    forever begin
      gap = sink_idling ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Leaves tvalid high after acceptance so that back-to-back transactions stay clean
  task automatic send_item(logic [1:0] mode, logic [7:0] ch, logic [10:0] idx);
    int gap;
    gap = src_idling ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {3'b000, idx, ch, mode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(console_apply(mode, ch, idx));
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(MODE_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_item(MODE_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_colour(logic sel, logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_FG) fg_colour = val;
    else bg_colour = val;
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch >= CH_TAB && ch <= CH_CR);
    return ch;
  endfunction

  function automatic logic [10:0] read_index();
    int pick;
    int pos;
    pick = $urandom_range(0, 9);
    pos  = cur_row * COLUMNS + cur_col;
    if (pick < 6) begin
      pos -= $urandom_range(1, 160);
      return 11'(pos < 0 ? 0 : pos);
    end else if (pick < 9) begin
      return 11'($urandom_range(0, CELLS - 1));
    end
    return 11'($urandom_range(CELLS, 2047));
  endfunction

  task automatic test_reset_screen();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    wait_idle();
  endtask

  task automatic test_byte_extremes();
    put_char(8'h00);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(8'hFF);
    for (int i = 0; i < 4; i++) read_cell(11'(i));
    wait_idle();
  endtask

  task automatic test_control_bytes();
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_VT);
    put_char(CH_FF);
    put_char(CH_LF);
    put_char(CH_TAB);
    read_cell(11'd4);
    wait_idle();
  endtask

  task automatic test_clear_keeps_cursor();
    put_char(8'h41);
    send_item(MODE_CLEAR, 8'hAA, 11'h555);
    read_cell(11'(2 * COLUMNS + 4));
    wait_idle();
  endtask

  // Mostly lines of text with reads in between, some tab runs, clears and noise
  task automatic run_random_traffic(int n_items);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(0, 100);
        for (int i = 0; i < len; i++) put_char(printable_byte());
        sent += len + 1;
        case ($urandom_range(0, 4))
          0: put_char(CH_LF);
          1: begin
            put_char(CH_CR);
            put_char(CH_LF);
            sent++;
          end
          2: put_char(CH_VT);
          3: put_char(CH_FF);
          default: put_char(printable_byte());
        endcase
      end else if (kind == 5) begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) put_char(CH_TAB);
        sent += len;
      end else if (kind < 8) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) read_cell(read_index());
        sent += len;
      end else if (kind == 8) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
        sent += len;
      end else begin
        send_item(MODE_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic test_colour_phases();
    logic [3:0] fg_set [4] = '{4'd0, 4'd15, 4'd0, 4'd15};
    logic [3:0] bg_set [4] = '{4'd0, 4'd15, 4'd15, 4'd0};
    for (int p = 0; p < 8; p++) begin
      if (p < 4) begin
        write_colour(REG_FG, fg_set[p]);
        write_colour(REG_BG, bg_set[p]);
      end else begin
        write_colour(REG_FG, 4'($urandom_range(0, 15)));
        write_colour(REG_BG, 4'($urandom_range(0, 15)));
      end
      src_idling  = ($urandom_range(0, 3) != 0);
      sink_idling = ($urandom_range(0, 3) != 0);
      run_random_traffic(210);
    end
  endtask

  initial begin
    blank_screen();
    cur_col   = 0;
    cur_row   = 0;
    fg_colour = 4'd15;
    bg_colour = 4'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_screen();
    write_colour(REG_FG, 4'd10);
    write_colour(REG_BG, 4'd5);
    test_byte_extremes();
    test_control_bytes();
    test_clear_keeps_cursor();
    test_colour_phases();
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Worst case: every item a full-screen sweep with maximum gaps, several times over
  initial begin
    #150_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
